FILE: rtl/kslfu_pkg.sv
// ============================================================================
// kslfu_pkg
// Shared types and constants of the keyed slot cache with aging LFU eviction.
// ============================================================================
`default_nettype none

package kslfu_pkg;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned SlotW = 3;
  localparam int unsigned UseW  = 8;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 24;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [UseW-1:0]  use_t;
  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE_RD,
    ST_AGE_WR,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/keyed_slot_cache_lfu_aging_top.sv
// ============================================================================
// keyed_slot_cache_lfu_aging_top
// Key lookup cache with round-robin aging and least-used replacement.
// ============================================================================
//
//  Channel   Direction  Payload (tdata / tuser)
//  s_axis    in         tdata: key[15:0]
//  m_axis    out        tdata: slot[2:0], evicted_key[18:3]; tuser: hit
//
//  A lookup runs the aging read and write, then the scan, which reads one slot
//  per cycle from the single read port of the key and usage memories and
//  compares it; a hit stops the scan, a miss scans every slot. The next input
//  can be taken in the cycle after the result has been taken.
//  Reset clears the valid bits; a slot that was never written reads as zero.
//  The block takes no new transaction until the result has been taken.
//
`default_nettype none

module keyed_slot_cache_lfu_aging_top #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned MAX_USE   = 127
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  wire logic [kslfu_pkg::InTdataW-1:0]       s_axis_tdata_i,   // key[15:0]
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  output logic [kslfu_pkg::OutTdataW-1:0]           m_axis_tdata_o,   // slot, evicted_key
  output logic                                      m_axis_tuser_o    // hit
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(NUM_SLOTS - 1);
  localparam logic [IdxW:0]   NumSlots = (IdxW + 1)'(NUM_SLOTS);
  localparam logic [kslfu_pkg::UseW:0] MaxUseX = (kslfu_pkg::UseW + 1)'(MAX_USE);
  localparam logic [kslfu_pkg::UseW:0] BestInit = {1'b1, {kslfu_pkg::UseW{1'b0}}};
  localparam int unsigned PadW =
    kslfu_pkg::OutTdataW - kslfu_pkg::SlotW - kslfu_pkg::KeyW;

  function automatic kslfu_pkg::use_t bump_use(input kslfu_pkg::use_t u);
    logic [kslfu_pkg::UseW:0] s;
    s = {1'b0, u} + (kslfu_pkg::UseW + 1)'(2);
    if (s > MaxUseX) begin
      s = MaxUseX;
    end
    return s[kslfu_pkg::UseW-1:0];
  endfunction

  kslfu_pkg::state_e state_q, state_d;

  kslfu_pkg::key_t key_mem_q [NUM_SLOTS];
  kslfu_pkg::use_t use_mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] key_vld_q, use_vld_q;

  kslfu_pkg::key_t key_rdata_q;
  kslfu_pkg::use_t use_rdata_q;
  logic            key_rvld_q, use_rvld_q;
  kslfu_pkg::key_t key_rd;
  kslfu_pkg::use_t use_rd;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            key_we, use_we;
  logic [IdxW-1:0] key_waddr, use_waddr;
  kslfu_pkg::key_t key_wdata;
  kslfu_pkg::use_t use_wdata;

  logic [IdxW-1:0] age_ptr_q, age_ptr_d, age_next;
  kslfu_pkg::key_t key_q, key_d;
  logic [IdxW:0]   scan_cnt_q, scan_cnt_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d;
  kslfu_pkg::use_t match_use_q, match_use_d;
  logic [kslfu_pkg::UseW:0] best_use_q, best_use_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  kslfu_pkg::key_t best_key_q, best_key_d;

  logic            in_xact, out_xact;
  logic            key_match, scan_last;
  kslfu_pkg::slot_t out_slot;
  kslfu_pkg::key_t  out_evict;

  assign in_xact   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xact  = m_axis_tvalid_o && m_axis_tready_i;
  assign age_next  = (age_ptr_q == LastIdx) ? '0 : age_ptr_q + IdxW'(1);
  assign key_rd    = key_rvld_q ? key_rdata_q : '0;
  assign use_rd    = use_rvld_q ? use_rdata_q : '0;
  assign key_match = cmp_vld_q && (key_rd == key_q);
  assign scan_last = cmp_vld_q && (cmp_idx_q == LastIdx);

  always_comb begin
    state_d = state_q;
    case (state_q)
      kslfu_pkg::ST_IDLE: begin
        if (in_xact) begin
          state_d = kslfu_pkg::ST_AGE_RD;
        end
      end
      kslfu_pkg::ST_AGE_RD: state_d = kslfu_pkg::ST_AGE_WR;
      kslfu_pkg::ST_AGE_WR: state_d = kslfu_pkg::ST_SCAN;
      kslfu_pkg::ST_SCAN: begin
        if (key_match || scan_last) begin
          state_d = kslfu_pkg::ST_UPDATE;
        end
      end
      kslfu_pkg::ST_UPDATE: state_d = kslfu_pkg::ST_OUT;
      kslfu_pkg::ST_OUT: begin
        if (out_xact) begin
          state_d = kslfu_pkg::ST_IDLE;
        end
      end
      default: state_d = kslfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_cnt_q[IdxW-1:0];
    key_we      = 1'b0;
    use_we      = 1'b0;
    key_waddr   = best_idx_q;
    use_waddr   = age_ptr_q;
    key_wdata   = key_q;
    use_wdata   = use_rd - kslfu_pkg::UseW'(1);
    age_ptr_d   = age_ptr_q;
    key_d       = key_q;
    scan_cnt_d  = scan_cnt_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    hit_d       = hit_q;
    match_idx_d = match_idx_q;
    match_use_d = match_use_q;
    best_use_d  = best_use_q;
    best_idx_d  = best_idx_q;
    best_key_d  = best_key_q;
    case (state_q)
      kslfu_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_xact) begin
          key_d      = s_axis_tdata_i[kslfu_pkg::KeyW-1:0];
          scan_cnt_d = '0;
          hit_d      = 1'b0;
          best_use_d = BestInit;
          best_idx_d = '0;
          best_key_d = '0;
        end
      end
      kslfu_pkg::ST_AGE_RD: begin
        rd_en     = 1'b1;
        rd_addr   = age_next;
        age_ptr_d = age_next;
      end
      kslfu_pkg::ST_AGE_WR: begin
        use_we = (use_rd != '0);
      end
      kslfu_pkg::ST_SCAN: begin
        if (scan_cnt_q < NumSlots) begin
          rd_en      = 1'b1;
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = scan_cnt_q[IdxW-1:0];
          scan_cnt_d = scan_cnt_q + (IdxW + 1)'(1);
        end
        if (key_match) begin
          hit_d       = 1'b1;
          match_idx_d = cmp_idx_q;
          match_use_d = use_rd;
        end else if (cmp_vld_q && ({1'b0, use_rd} < best_use_q)) begin
          best_use_d = {1'b0, use_rd};
          best_idx_d = cmp_idx_q;
          best_key_d = key_rd;
        end
      end
      kslfu_pkg::ST_UPDATE: begin
        use_we = 1'b1;
        if (hit_q) begin
          use_waddr = match_idx_q;
          use_wdata = bump_use(match_use_q);
        end else begin
          key_we    = 1'b1;
          use_waddr = best_idx_q;
          use_wdata = bump_use('0);
        end
      end
      kslfu_pkg::ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  assign out_slot  = hit_q ? kslfu_pkg::SlotW'(match_idx_q) : kslfu_pkg::SlotW'(best_idx_q);
  assign out_evict = hit_q ? '0 : best_key_q;
  assign m_axis_tdata_o = {{PadW{1'b0}}, out_evict, out_slot};
  assign m_axis_tuser_o = hit_q;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem_q[key_waddr] <= key_wdata;
    end
    if (use_we) begin
      use_mem_q[use_waddr] <= use_wdata;
    end
    if (rd_en) begin
      key_rdata_q <= key_mem_q[rd_addr];
      use_rdata_q <= use_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kslfu_pkg::ST_IDLE;
      key_vld_q  <= '0;
      use_vld_q  <= '0;
      key_rvld_q <= 1'b0;
      use_rvld_q <= 1'b0;
      age_ptr_q  <= '0;
      scan_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      match_idx_q <= '0;
      best_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      age_ptr_q  <= age_ptr_d;
      scan_cnt_q <= scan_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      match_idx_q <= match_idx_d;
      best_idx_q <= best_idx_d;
      if (key_we) begin
        key_vld_q[key_waddr] <= 1'b1;
      end
      if (use_we) begin
        use_vld_q[use_waddr] <= 1'b1;
      end
      if (rd_en) begin
        key_rvld_q <= key_vld_q[rd_addr];
        use_rvld_q <= use_vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    cmp_idx_q   <= cmp_idx_d;
    match_use_q <= match_use_d;
    best_use_q  <= best_use_d;
    best_key_q  <= best_key_d;
  end

  a_accept_starts_aging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact |=> (state_q == kslfu_pkg::ST_AGE_RD))
    else $error("Accepted transaction did not start the aging step.");

  a_hit_has_no_eviction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[18:3] == '0))
    else $error("A hit reported a nonzero evicted key.");

  a_usage_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_we |-> (use_wdata <= kslfu_pkg::UseW'(MAX_USE)))
    else $error("Usage count written above its ceiling.");

  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kslfu_pkg::ST_SCAN) |-> (!key_we && !use_we))
    else $error("Memory written while the scan reads it.");

  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xact |=> (state_q == kslfu_pkg::ST_IDLE))
    else $error("Block did not return to idle after the result transaction.");

endmodule

`default_nettype wire

FILE: test/tb.sv
// ============================================================================
// tb
// Self-checking testbench of the keyed slot cache with aging LFU eviction.
// A short table of directed lookups covers the reset contents, the extremes
// of the key and the first misses and hits. It is followed by random lookups
// drawn mostly from small key pools, so that hits, evictions, duplicate keys
// and usage saturation all occur. Given rows are checked against the table,
// the rest against a cycle-free cache model in the bench. Both streams idle and stall at random.
// ============================================================================
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots       = 8;
  localparam int unsigned MaxUse      = 127;
  localparam int unsigned NumRandom   = 1680;
  localparam int unsigned DirRows     = 17;
  localparam int unsigned DrainCycles = 4 * Slots + 10;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam logic        Hit         = 1'b1;
  localparam logic        Miss        = 1'b0;

  typedef struct packed {
    kslfu_pkg::slot_t slot;
    logic             hit;
    kslfu_pkg::key_t  evicted;
  } lookup_t;

  // Directed stimulus: key, result given, then the given slot, hit and evicted key.
  typedef struct packed {
    kslfu_pkg::key_t  key;
    logic             given;
    kslfu_pkg::slot_t slot;
    logic             hit;
    kslfu_pkg::key_t  evicted;
  } row_t;

  row_t dir_rows [DirRows] = '{
    {16'h0000, 1'b1, 3'd0, Hit,  16'h0000},
    {16'hFFFF, 1'b1, 3'd1, Miss, 16'h0000},
    {16'hFFFF, 1'b1, 3'd1, Hit,  16'h0000},
    {16'h0001, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h8000, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h5555, 1'b0, 3'd0, Miss, 16'h0000},
    {16'hAAAA, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h00FF, 1'b0, 3'd0, Miss, 16'h0000},
    {16'hFF00, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h7FFF, 1'b0, 3'd0, Miss, 16'h0000},
    {16'hFFFE, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h0000, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h0001, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h8000, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h1234, 1'b0, 3'd0, Miss, 16'h0000},
    {16'hFFFF, 1'b0, 3'd0, Miss, 16'h0000},
    {16'h0000, 1'b0, 3'd0, Miss, 16'h0000}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [kslfu_pkg::InTdataW-1:0]  s_axis_tdata = '0;    // key
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [kslfu_pkg::OutTdataW-1:0] m_axis_tdata;         // slot, evicted_key
  logic                            m_axis_tuser;         // hit

  kslfu_pkg::key_t cache_key [Slots];
  logic [7:0]      cache_use [Slots];
  int unsigned     age_ptr;

  lookup_t     lookups_pending [$];
  logic        row_given = 1'b0;
  lookup_t     row_result = '0;
  logic        steady = 1'b0;
  logic        ready_now = 1'b0;
  int unsigned ready_run = 0;
  int unsigned errs = 0;
  int unsigned cycles = 0;

  keyed_slot_cache_lfu_aging_top #(
    .NUM_SLOTS(Slots),
    .MAX_USE  (MaxUse)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] bumped(logic [7:0] u);
    int unsigned v;
    v = u + 2;
    if (v > MaxUse) v = MaxUse;
    return v[7:0];
  endfunction

  function automatic lookup_t predict_lookup(kslfu_pkg::key_t k);
    lookup_t     r;
    int unsigned best;
    int unsigned best_use;
    age_ptr = (age_ptr + 1) % Slots;
    if (cache_use[age_ptr] != 0) cache_use[age_ptr] = cache_use[age_ptr] - 1;
    best = 0;
    best_use = 32'hFFFF_FFFF;
    for (int i = 0; i < Slots; i++) begin
      if (cache_key[i] == k) begin
        cache_use[i] = bumped(cache_use[i]);
        r.slot = kslfu_pkg::slot_t'(i);
        r.hit = Hit;
        r.evicted = '0;
        return r;
      end
      if (cache_use[i] < best_use) begin
        best_use = cache_use[i];
        best = i;
      end
    end
    r.slot = kslfu_pkg::slot_t'(best);
    r.hit = Miss;
    r.evicted = cache_key[best];
    cache_key[best] = k;
    cache_use[best] = bumped(8'd0);
    return r;
  endfunction

  task automatic send_key(input kslfu_pkg::key_t k, input logic given, input lookup_t res);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= k;
    row_given = given;
    row_result = res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (ready_run == 0) begin
      if (steady || $urandom_range(0, 99) < 70) begin
        ready_now = 1'b1;
        ready_run = $urandom_range(1, 20);
      end else begin
        ready_now = 1'b0;
        ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end else begin
      ready_run = ready_run - 1;
    end
    m_axis_tready <= ready_now;
  end

  always @(posedge clk_i) begin : check_results
    lookup_t want;
    lookup_t got;
    lookup_t pred;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = predict_lookup(s_axis_tdata);
        lookups_pending.push_back(row_given ? row_result : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.slot = m_axis_tdata[2:0];
        got.evicted = m_axis_tdata[18:3];
        got.hit = m_axis_tuser;
        if (lookups_pending.size() == 0) begin
          $error("unexpected result: slot %0d hit %0b evicted_key %h",
                 got.slot, got.hit, got.evicted);
          errs++;
        end else begin
          want = lookups_pending.pop_front();
          if (got.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            errs++;
          end
          if (got.hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, got.hit);
            errs++;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted_key: expected %h, actual %h", want.evicted, got.evicted);
            errs++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    kslfu_pkg::key_t pool [16];
    int unsigned     pool_size;
    int unsigned     sent;
    int unsigned     run_len;
    int unsigned     r;
    kslfu_pkg::key_t k;
    for (int i = 0; i < Slots; i++) begin
      cache_key[i] = '0;
      cache_use[i] = '0;
    end
    age_ptr = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_key(dir_rows[i].key, dir_rows[i].given,
               {dir_rows[i].slot, dir_rows[i].hit, dir_rows[i].evicted});
    end
    s_axis_tvalid <= 1'b0;
    while (lookups_pending.size() != 0) @(negedge clk_i);

    // A long run of one key drives its usage count into saturation.
    k = kslfu_pkg::key_t'($urandom);
    for (int i = 0; i < 100; i++) send_key(k, 1'b0, '0);
    sent = 100;
    pool_size = 0;

    while (sent < NumRandom) begin
      if (pool_size == 0 || $urandom_range(0, 149) == 0) begin
        pool_size = $urandom_range(4, 14);
        for (int i = 0; i < 16; i++) begin
          if (i > 0 && $urandom_range(0, 2) == 0)
            pool[i] = pool[i-1] ^ (kslfu_pkg::key_t'(1) << $urandom_range(0, 15));
          else
            pool[i] = kslfu_pkg::key_t'($urandom);
        end
        if ($urandom_range(0, 1) == 0) begin
          s_axis_tvalid <= 1'b0;
          while (lookups_pending.size() != 0) @(negedge clk_i);
        end
      end
      steady = (sent >= 700 && sent < 900);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        k = pool[$urandom_range(0, pool_size - 1)];
        run_len = $urandom_range(10, 60);
        for (int i = 0; i < run_len; i++) send_key(k, 1'b0, '0);
        sent += run_len;
      end else begin
        if (r < 63) k = pool[$urandom_range(0, pool_size - 1)];
        else if (r < 80) k = kslfu_pkg::key_t'($urandom);
        else if (r < 85) k = '0;
        else if (r < 90) k = '1;
        else if (r < 95) k = kslfu_pkg::key_t'(1) << $urandom_range(0, 15);
        else k = ~(kslfu_pkg::key_t'(1) << $urandom_range(0, 15));
        send_key(k, 1'b0, '0);
        sent++;
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (lookups_pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errs == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/kslfu_pkg.sv
rtl/keyed_slot_cache_lfu_aging_top.sv
test/tb.sv
